// ----- rtl/core/tta_pkg.sv -----
// Package of the tiled texel address generator.
// Holds the configuration register indexes, the layout codes and the configuration struct.
// No dependencies.
package tta_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int OFFSET_BITS    = 32;
   localparam int FACE_BITS      = 3;
   localparam int PITCH_BITS     = 18;
   localparam int SLICE_BITS     = 14;
   localparam int SIZE_LOG2_BITS = 3;

   // Tile geometry, in bytes and rows.
   localparam int X_TILE_WIDTH_LOG2  = 9;   // 512-byte tile rows
   localparam int X_TILE_ROWS_LOG2   = 3;   // 8 rows per tile
   localparam int Y_COLUMN_WIDTH_LOG2 = 4;  // 16-byte columns
   localparam int Y_TILE_ROWS_LOG2   = 5;   // 32 rows per column
   localparam int TILE_BYTES_LOG2    = 12;  // 4 KiB tiles

   localparam logic [SIZE_LOG2_BITS-1:0] TEXEL_SIZE_LOG2_RESET = 3'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TILE_LAYOUT     = 3'd0,
      CSR_TEXEL_SIZE_LOG2 = 3'd1,
      CSR_ROW_PITCH       = 3'd2,
      CSR_SLICE_ROWS      = 3'd3,
      CSR_CUBE_ENABLE     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      LAYOUT_LINEAR      = 2'd0,
      LAYOUT_X_MAJOR     = 2'd1,
      LAYOUT_Y_MAJOR     = 2'd2,
      LAYOUT_UNSUPPORTED = 2'd3
   } layout_type;

   typedef struct packed {
      layout_type                tile_layout;
      logic [SIZE_LOG2_BITS-1:0] texel_size_log2;
      logic [PITCH_BITS-1:0]     row_pitch;
      logic [SLICE_BITS-1:0]     slice_rows;
      logic                      cube_enable;
      logic [OFFSET_BITS-1:0]    slice_bytes;  // row_pitch * slice_rows, registered
   } cfg_type;

endpackage

// ----- rtl/core/tta_csr.sv -----
// Configuration registers of the tiled texel address generator.
// Also keeps the registered product of row pitch and slice rows. Depends on tta_pkg.
module tta_csr
   import tta_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output cfg_type                   cfg
);

   layout_type                          tile_layout_ff;
   logic [SIZE_LOG2_BITS-1:0]           texel_size_log2_ff;
   logic [PITCH_BITS-1:0]               row_pitch_ff;
   logic [SLICE_BITS-1:0]               slice_rows_ff;
   logic                                cube_enable_ff;
   logic [PITCH_BITS+SLICE_BITS-1:0]    slice_prod;
   logic [OFFSET_BITS-1:0]              slice_bytes_ff;
   logic [OFFSET_BITS-1:0]              slice_bytes_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_layout_ff     <= LAYOUT_LINEAR;
         texel_size_log2_ff <= TEXEL_SIZE_LOG2_RESET;
         row_pitch_ff       <= '0;
         slice_rows_ff      <= '0;
         cube_enable_ff     <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TILE_LAYOUT:     tile_layout_ff     <= layout_type'(csr_data[1:0]);
            CSR_TEXEL_SIZE_LOG2: texel_size_log2_ff <= csr_data[SIZE_LOG2_BITS-1:0];
            CSR_ROW_PITCH:       row_pitch_ff       <= csr_data[PITCH_BITS-1:0];
            CSR_SLICE_ROWS:      slice_rows_ff      <= csr_data[SLICE_BITS-1:0];
            CSR_CUBE_ENABLE:     cube_enable_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // An 18 by 14 bit product fits in 32 bits exactly. It is registered and settles
   // after a write, before any item that follows the write reaches the datapath.
   assign slice_prod     = row_pitch_ff * slice_rows_ff;
   assign slice_bytes_in = OFFSET_BITS'(slice_prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_bytes_ff <= '0;
      end else begin
         slice_bytes_ff <= slice_bytes_in;
      end
   end

   always_comb begin
      cfg.tile_layout     = tile_layout_ff;
      cfg.texel_size_log2 = texel_size_log2_ff;
      cfg.row_pitch       = row_pitch_ff;
      cfg.slice_rows      = slice_rows_ff;
      cfg.cube_enable     = cube_enable_ff;
      cfg.slice_bytes     = slice_bytes_ff;
   end

endmodule

// ----- rtl/core/tta_offset.sv -----
// Combinational byte offset calculation for the linear, X-major and Y-major layouts.
// One row multiplier shared by the three layouts plus a small face multiply. Depends on tta_pkg.
module tta_offset
   import tta_pkg::*;
#(
   parameter int COORD_BITS = 14
) (
   input  cfg_type                cfg,
   input  logic [COORD_BITS-1:0]  texel_u,
   input  logic [COORD_BITS-1:0]  texel_v,
   input  logic [FACE_BITS-1:0]   cube_face,
   output logic [OFFSET_BITS-1:0] byte_offset,
   output logic                   layout_unsupported
);

   logic [COORD_BITS-1:0]            mul_rows;
   logic [COORD_BITS+PITCH_BITS-1:0] prod_full;
   logic [OFFSET_BITS-1:0]           prod;
   logic [OFFSET_BITS-1:0]           ub;
   logic [OFFSET_BITS-1:0]           face_bytes;

   // Texel column in bytes; shifts of five to seven are honored as written.
   assign ub = OFFSET_BITS'(OFFSET_BITS'(texel_u) << cfg.texel_size_log2);

   // The row multiplier sees whole rows, whole tile rows or whole column rows.
   always_comb begin
      unique case (cfg.tile_layout)
         LAYOUT_X_MAJOR: mul_rows = texel_v >> X_TILE_ROWS_LOG2;
         LAYOUT_Y_MAJOR: mul_rows = texel_v >> Y_TILE_ROWS_LOG2;
         default:        mul_rows = texel_v;
      endcase
   end

   assign prod_full = mul_rows * cfg.row_pitch;
   assign prod      = OFFSET_BITS'(prod_full);

   // Face times slice bytes, as shifts and adds of a three-bit multiplier.
   assign face_bytes = (cube_face[0] ? cfg.slice_bytes : '0)
                     + (cube_face[1] ? (cfg.slice_bytes << 1) : '0)
                     + (cube_face[2] ? (cfg.slice_bytes << 2) : '0);

   always_comb begin
      byte_offset        = '0;
      layout_unsupported = 1'b0;
      unique case (cfg.tile_layout)
         LAYOUT_LINEAR: begin
            byte_offset = ub + prod;
         end
         LAYOUT_X_MAJOR: begin
            byte_offset = (prod << X_TILE_ROWS_LOG2)
                        + (OFFSET_BITS'(texel_v[X_TILE_ROWS_LOG2-1:0]) << X_TILE_WIDTH_LOG2)
                        + OFFSET_BITS'(ub[X_TILE_WIDTH_LOG2-1:0])
                        + ((ub >> X_TILE_WIDTH_LOG2) << TILE_BYTES_LOG2);
         end
         LAYOUT_Y_MAJOR: begin
            byte_offset = (prod << Y_TILE_ROWS_LOG2)
                        + (cfg.cube_enable ? face_bytes : '0)
                        + (OFFSET_BITS'(texel_v[Y_TILE_ROWS_LOG2-1:0])
                           << Y_COLUMN_WIDTH_LOG2)
                        + OFFSET_BITS'(ub[Y_COLUMN_WIDTH_LOG2-1:0])
                        + ((ub >> Y_COLUMN_WIDTH_LOG2)
                           << (Y_COLUMN_WIDTH_LOG2 + Y_TILE_ROWS_LOG2));
         end
         LAYOUT_UNSUPPORTED: begin
            byte_offset        = '0;
            layout_unsupported = 1'b1;
         end
         default: begin
            byte_offset        = '0;
            layout_unsupported = 1'b1;
         end
      endcase
   end

endmodule

// ----- rtl/core/tiled_texel_address_generator.sv -----
// Top level of the tiled texel address generator.
// Instantiates tta_csr and tta_offset and holds the input and result registers.
// Depends on tta_pkg.
//
// Usage. The request channel (req_valid, req_ready, req_texel_u, req_texel_v,
// req_cube_face) carries one texel coordinate per transfer. The response
// channel (rsp_valid, rsp_ready, rsp_byte_offset, rsp_layout_unsupported)
// returns one byte offset per request, in request order. The configuration
// channel (csr_valid, csr_ready, csr_index, csr_data) writes one register per
// transfer and is always ready; indexes beyond the register list are ignored.
// Registers are to be written by the user only while no request is in flight;
// the block does not enforce this. req_ready is held low while csr_valid is high
// so that no request shares an edge with a write.
//
// A request that is taken sits in the input register; the offset logic loads the
// result register when that is free, and rsp_valid rises with it. Throughput is
// one request per cycle while rsp_ready is high and csr_valid is low, set by the
// single-pass datapath between the two registers. The product of row pitch and
// slice rows is registered and settles after a write to either register.
//
// Synchronous reset clears both stage valid bits and loads the register reset
// values. When the receiver stalls, the result register holds, the input
// register fills behind it, and only then does req_ready drop.
module tiled_texel_address_generator
   import tta_pkg::*;
#(
   parameter int COORD_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [COORD_BITS-1:0]     req_texel_u,
   input  logic [COORD_BITS-1:0]     req_texel_v,
   input  logic [FACE_BITS-1:0]      req_cube_face,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [OFFSET_BITS-1:0]    rsp_byte_offset,
   output logic                      rsp_layout_unsupported,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type cfg;

   // Input stage.
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [COORD_BITS-1:0]  in_u_ff;
   logic [COORD_BITS-1:0]  in_v_ff;
   logic [FACE_BITS-1:0]   in_face_ff;

   // Result stage.
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [OFFSET_BITS-1:0] out_offset_ff;
   logic                   out_bad_ff;

   logic [OFFSET_BITS-1:0] calc_offset;
   logic                   calc_bad;
   logic                   out_free;
   logic                   advance;
   logic                   req_take;

   tta_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tta_offset #(
      .COORD_BITS (COORD_BITS)
   ) u_addr_calc (
      .cfg                (cfg),
      .texel_u            (in_u_ff),
      .texel_v            (in_v_ff),
      .cube_face          (in_face_ff),
      .byte_offset        (calc_offset),
      .layout_unsupported (calc_bad)
   );

   // The result register can take a new value when it is empty or being drained.
   // A request never enters on the edge of a register write, so every request taken
   // after a write sees the written value and the settled pitch-by-slice product.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = (!in_valid_ff || out_free) && !csr_valid;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_u_ff    <= req_texel_u;
         in_v_ff    <= req_texel_v;
         in_face_ff <= req_cube_face;
      end
      if (advance) begin
         out_offset_ff <= calc_offset;
         out_bad_ff    <= calc_bad;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_byte_offset        = out_offset_ff;
   assign rsp_layout_unsupported = out_bad_ff;

endmodule
